FILE: src/ngm_pkg.sv
// ----------------------------------------------------------------------------
// ngm_pkg
// shared constants and codes of the keyword n-gram matcher
// ----------------------------------------------------------------------------
package ngm_pkg;

  localparam int unsigned DEF_MAX_SPAN     = 4;
  localparam int unsigned DEF_NUM_PATTERNS = 256;
  localparam int unsigned DEF_TOKEN_BITS   = 20;
  localparam int unsigned DEF_MAX_TEXT_LEN = 65536;

  // results kept per transaction, extra ones are dropped
  localparam int unsigned MAX_RESULTS = 10;
  // width of the reported positions
  localparam int unsigned OUT_POS_W   = 16;

  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MATCH      = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_TRUNCATED  = 2'd3
  } status_e;

endpackage

FILE: src/ngm_pattern_mem.sv
// ----------------------------------------------------------------------------
// ngm_pattern_mem
// pattern table, one row per pattern, one write and one registered read port
// ----------------------------------------------------------------------------
module ngm_pattern_mem #(
  parameter int unsigned ROW_W = 84,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [ROW_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [ROW_W-1:0] rdata_o
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ngm_match_unit.sv
// ----------------------------------------------------------------------------
// ngm_match_unit
// compares one table row against a token sequence, flags the hit by length
// ----------------------------------------------------------------------------
module ngm_match_unit #(
  parameter int unsigned MAX_SPAN   = 4,
  parameter int unsigned TOKEN_BITS = 20,
  parameter int unsigned LEN_W      = 3
) (
  input  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] row_tokens_i,
  input  logic [LEN_W-1:0]                    row_len_i,
  input  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] seq_i,
  input  logic [LEN_W-1:0]                    lim_i,
  output logic [MAX_SPAN-1:0]                 hit_o
);

  logic prefix_ok;

  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < MAX_SPAN; i++) begin
      if ((LEN_W'(i) < row_len_i) && (row_tokens_i[i] != seq_i[i])) begin
        prefix_ok = 1'b0;
      end
    end
    for (int l = 0; l < MAX_SPAN; l++) begin
      hit_o[l] = prefix_ok && (row_len_i == LEN_W'(l + 1)) && (LEN_W'(l + 1) <= lim_i);
    end
  end

endmodule

FILE: src/token_ngram_keyword_matcher.sv
// ----------------------------------------------------------------------------
// token_ngram_keyword_matcher
// keyword n-gram table with a streaming text window, reports matches or ranges
// ----------------------------------------------------------------------------
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+---------------------
//  command  | cmd_i, token_i, last_i                       | start & !busy
//  result   | status_o, range_start_o, range_end_o,        | result_valid_o strobe
//           | last_result_o                                |
//  config   | cfg_wdata_i (join_mode)                      | cfg_we_i
//
//  a pattern token that is not the last goes through accept and done, as does
//  a too-long pattern; the last token of a pattern scans the table once:
//  accept, the table scan, store or report, done.
//  a text token scans the table once per checked start (one start normally,
//  up to MAX_SPAN on the last token); each start scans the table rows, then
//  steps once per span length and once to settle; the table has a single
//  read port, so the rows of a scan are read one after another.
//  at most one result per cycle; each result is held until the next one or
//  the end of the transaction, the last one shows in the first idle cycle.
//  reset clears the table count, the window and all range tracking.
//  the receiver cannot stall, results are never held back.
// ----------------------------------------------------------------------------
module token_ngram_keyword_matcher #(
  parameter int unsigned MAX_SPAN     = ngm_pkg::DEF_MAX_SPAN,
  parameter int unsigned NUM_PATTERNS = ngm_pkg::DEF_NUM_PATTERNS,
  parameter int unsigned TOKEN_BITS   = ngm_pkg::DEF_TOKEN_BITS,
  parameter int unsigned MAX_TEXT_LEN = ngm_pkg::DEF_MAX_TEXT_LEN
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic [TOKEN_BITS-1:0]        token_i,
  input  logic                         last_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic [ngm_pkg::OUT_POS_W-1:0] range_start_o,
  output logic [ngm_pkg::OUT_POS_W-1:0] range_end_o,
  output logic                         last_result_o
);

  import ngm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_SPAN + 1);
  localparam int unsigned CW    = $clog2(NUM_PATTERNS + 1);
  localparam int unsigned AW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int unsigned PW    = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned RCW   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned ROW_W = LEN_W + MAX_SPAN * TOKEN_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PAT, S_EMIT, S_SETTLE, S_FLUSH, S_CLOSE, S_TRUNC, S_DONE
  } state_e;

  typedef logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] tok_vec_t;

  state_e            state_q;
  logic              join_q;
  logic [CW-1:0]     count_q;
  logic [LEN_W-1:0]  fill_q;
  logic              overlong_q;
  tok_vec_t          staging_q;
  tok_vec_t          window_q;
  logic [PW-1:0]     pos_q;
  logic [MAX_SPAN-1:0] cov_q;
  logic              open_q;
  logic [PW-1:0]     open_start_q;
  logic [PW-1:0]     lp_q;          // position of the last kept text token
  logic [PW-1:0]     cpos_q;        // text position of the start being checked
  logic [LEN_W-1:0]  j_q;           // window slot of that start
  logic [LEN_W-1:0]  len_q;
  logic [MAX_SPAN-1:0] hit_q;       // hits by span length from the last scan
  logic [CW-1:0]     scan_idx_q;
  logic              row_vld_q;
  logic              text_mode_q;
  logic              in_flush_q;
  logic              trunc_q;
  logic              last_q;

  // result staging: one held result so the final one can carry its mark
  logic              pend_vld_q;
  logic [1:0]        pend_status_q;
  logic [OUT_POS_W-1:0] pend_start_q;
  logic [OUT_POS_W-1:0] pend_end_q;
  logic [RCW-1:0]    res_cnt_q;
  logic              strobe_q;
  logic [1:0]        status_q;
  logic [OUT_POS_W-1:0] rs_q;
  logic [OUT_POS_W-1:0] re_q;
  logic              lr_q;

  logic              accept;
  logic              mem_we;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_rdata;
  tok_vec_t          row_tokens;
  logic [LEN_W-1:0]  row_len;
  tok_vec_t          seq;
  logic [LEN_W-1:0]  lim;
  logic [MAX_SPAN-1:0] hit_w;
  logic              hit_sel;       // hit at the current span length
  logic              dup;           // staged pattern already in the table
  logic              covered;
  logic [MAX_SPAN-1:0] cov_add;
  logic [LEN_W-1:0]  flush_j;
  logic [PW-1:0]     flush_pos;
  logic              emit_req;
  logic [1:0]        emit_status;
  logic [OUT_POS_W-1:0] emit_start;
  logic [OUT_POS_W-1:0] emit_end;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign mem_re = (state_q == S_SCAN) && (scan_idx_q < count_q);
  assign mem_we = (state_q == S_PAT) && !dup && (count_q < CW'(NUM_PATTERNS));
  assign row_tokens = mem_rdata[MAX_SPAN*TOKEN_BITS-1:0];
  assign row_len    = mem_rdata[ROW_W-1 -: LEN_W];

  ngm_pattern_mem #(
    .ROW_W (ROW_W),
    .DEPTH (NUM_PATTERNS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({fill_q, staging_q}),
    .re_i    (mem_re),
    .raddr_i (scan_idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // compare sequence: the window from the checked slot, or the staged pattern
  always_comb begin
    for (int i = 0; i < MAX_SPAN; i++) begin
      seq[i] = '0;
      for (int k = 0; k < MAX_SPAN; k++) begin
        if (int'(j_q) + i == k) begin
          seq[i] = window_q[k];
        end
      end
    end
    if (!text_mode_q) begin
      seq = staging_q;
    end
    lim = text_mode_q ? (LEN_W'(MAX_SPAN) - j_q) : fill_q;
  end

  ngm_match_unit #(
    .MAX_SPAN   (MAX_SPAN),
    .TOKEN_BITS (TOKEN_BITS),
    .LEN_W      (LEN_W)
  ) u_match (
    .row_tokens_i (row_tokens),
    .row_len_i    (row_len),
    .seq_i        (seq),
    .lim_i        (lim),
    .hit_o        (hit_w)
  );

  // per-slot selections and flush start
  always_comb begin
    hit_sel = 1'b0;
    dup     = 1'b0;
    covered = 1'b0;
    for (int l = 0; l < MAX_SPAN; l++) begin
      if (len_q == LEN_W'(l + 1)) begin
        hit_sel = hit_q[l];
      end
      if (fill_q == LEN_W'(l + 1)) begin
        dup = hit_q[l];
      end
      if (j_q == LEN_W'(l)) begin
        covered = cov_q[l];
      end
      cov_add[l] = (LEN_W'(l) >= j_q) && (int'(l) < int'(j_q) + int'(len_q));
    end
    if (lp_q >= PW'(MAX_SPAN - 1)) begin
      flush_j   = LEN_W'(1);
      flush_pos = PW'(lp_q + PW'(2) - PW'(MAX_SPAN));
    end else begin
      flush_j   = LEN_W'(PW'(MAX_SPAN - 1) - lp_q);
      flush_pos = '0;
    end
  end

  // result requests, at most one per cycle
  always_comb begin
    emit_req    = 1'b0;
    emit_status = ST_MATCH;
    emit_start  = '0;
    emit_end    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_PATTERN) && last_i &&
            (overlong_q || (fill_q == LEN_W'(MAX_SPAN)))) begin
          emit_req    = 1'b1;
          emit_status = ST_TOO_LONG;
        end
      end
      S_PAT: begin
        if (!dup && (count_q >= CW'(NUM_PATTERNS))) begin
          emit_req    = 1'b1;
          emit_status = ST_TABLE_FULL;
        end
      end
      S_EMIT: begin
        if (hit_sel && !join_q) begin
          emit_req   = 1'b1;
          emit_start = OUT_POS_W'(cpos_q);
          emit_end   = OUT_POS_W'(cpos_q + PW'(len_q) - PW'(1));
        end
      end
      S_SETTLE: begin
        if (!covered && open_q && join_q) begin
          emit_req   = 1'b1;
          emit_start = OUT_POS_W'(open_start_q);
          emit_end   = OUT_POS_W'(cpos_q - PW'(1));
        end
      end
      S_CLOSE: begin
        if (open_q && join_q) begin
          emit_req   = 1'b1;
          emit_start = OUT_POS_W'(open_start_q);
          emit_end   = OUT_POS_W'(lp_q);
        end
      end
      S_TRUNC: begin
        emit_req    = 1'b1;
        emit_status = ST_TRUNCATED;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      join_q      <= 1'b0;
      count_q     <= '0;
      fill_q      <= '0;
      overlong_q  <= 1'b0;
      staging_q   <= '0;
      window_q    <= '0;
      pos_q       <= '0;
      cov_q       <= '0;
      open_q      <= 1'b0;
      open_start_q <= '0;
      lp_q        <= '0;
      cpos_q      <= '0;
      j_q         <= '0;
      len_q       <= '0;
      hit_q       <= '0;
      scan_idx_q  <= '0;
      row_vld_q   <= 1'b0;
      text_mode_q <= 1'b0;
      in_flush_q  <= 1'b0;
      trunc_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        join_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= last_i;
            case (cmd_i)
              CMD_PATTERN: begin
                if (!last_i) begin
                  if (fill_q < LEN_W'(MAX_SPAN)) begin
                    for (int i = 0; i < MAX_SPAN; i++) begin
                      if (fill_q == LEN_W'(i)) begin
                        staging_q[i] <= token_i;
                      end
                    end
                    fill_q <= fill_q + LEN_W'(1);
                  end else begin
                    overlong_q <= 1'b1;
                  end
                  state_q <= S_DONE;
                end else if (overlong_q || (fill_q == LEN_W'(MAX_SPAN))) begin
                  // too long, dropped with its status
                  fill_q     <= '0;
                  overlong_q <= 1'b0;
                  staging_q  <= '0;
                  state_q    <= S_DONE;
                end else begin
                  for (int i = 0; i < MAX_SPAN; i++) begin
                    if (fill_q == LEN_W'(i)) begin
                      staging_q[i] <= token_i;
                    end
                  end
                  fill_q      <= fill_q + LEN_W'(1);
                  text_mode_q <= 1'b0;
                  scan_idx_q  <= '0;
                  row_vld_q   <= 1'b0;
                  hit_q       <= '0;
                  state_q     <= S_SCAN;
                end
              end
              CMD_TEXT: begin
                if (pos_q >= PW'(MAX_TEXT_LEN)) begin
                  if (last_i) begin
                    lp_q    <= PW'(MAX_TEXT_LEN - 1);
                    trunc_q <= 1'b1;
                    state_q <= S_FLUSH;
                  end else begin
                    state_q <= S_DONE;
                  end
                end else begin
                  for (int i = 0; i + 1 < MAX_SPAN; i++) begin
                    window_q[i] <= window_q[i+1];
                  end
                  window_q[MAX_SPAN-1] <= token_i;
                  cov_q <= cov_q >> 1;
                  pos_q <= pos_q + PW'(1);
                  lp_q  <= pos_q;
                  if (pos_q >= PW'(MAX_SPAN - 1)) begin
                    j_q         <= '0;
                    cpos_q      <= PW'(pos_q + PW'(1) - PW'(MAX_SPAN));
                    in_flush_q  <= 1'b0;
                    text_mode_q <= 1'b1;
                    scan_idx_q  <= '0;
                    row_vld_q   <= 1'b0;
                    hit_q       <= '0;
                    state_q     <= S_SCAN;
                  end else if (last_i) begin
                    state_q <= S_FLUSH;
                  end else begin
                    state_q <= S_DONE;
                  end
                end
              end
              CMD_CLEAR: begin
                count_q    <= '0;
                fill_q     <= '0;
                overlong_q <= 1'b0;
                staging_q  <= '0;
                state_q    <= S_DONE;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx_q < count_q) begin
            scan_idx_q <= scan_idx_q + CW'(1);
            row_vld_q  <= 1'b1;
          end else begin
            row_vld_q <= 1'b0;
          end
          if (row_vld_q) begin
            hit_q <= hit_q | hit_w;
          end
          if ((scan_idx_q >= count_q) && !row_vld_q) begin
            if (text_mode_q) begin
              len_q   <= LEN_W'(MAX_SPAN) - j_q;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_PAT;
            end
          end
        end
        S_PAT: begin
          if (mem_we) begin
            count_q <= count_q + CW'(1);
          end
          fill_q     <= '0;
          overlong_q <= 1'b0;
          staging_q  <= '0;
          state_q    <= S_DONE;
        end
        S_EMIT: begin
          if (hit_sel) begin
            cov_q <= cov_q | cov_add;
          end
          if (len_q == LEN_W'(1)) begin
            state_q <= S_SETTLE;
          end else begin
            len_q <= len_q - LEN_W'(1);
          end
        end
        S_SETTLE: begin
          if (covered && !open_q) begin
            open_start_q <= cpos_q;
            open_q       <= 1'b1;
          end else if (!covered && open_q) begin
            open_q <= 1'b0;
          end
          if (in_flush_q) begin
            if (int'(j_q) + 1 < MAX_SPAN) begin
              j_q        <= j_q + LEN_W'(1);
              cpos_q     <= cpos_q + PW'(1);
              scan_idx_q <= '0;
              row_vld_q  <= 1'b0;
              hit_q      <= '0;
              state_q    <= S_SCAN;
            end else begin
              state_q <= S_CLOSE;
            end
          end else if (last_q) begin
            state_q <= S_FLUSH;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FLUSH: begin
          if (flush_j < LEN_W'(MAX_SPAN)) begin
            j_q         <= flush_j;
            cpos_q      <= flush_pos;
            in_flush_q  <= 1'b1;
            text_mode_q <= 1'b1;
            scan_idx_q  <= '0;
            row_vld_q   <= 1'b0;
            hit_q       <= '0;
            state_q     <= S_SCAN;
          end else begin
            state_q <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          // text ends here, window and range tracking start over
          window_q     <= '0;
          pos_q        <= '0;
          cov_q        <= '0;
          open_start_q <= '0;
          open_q       <= 1'b0;
          in_flush_q   <= 1'b0;
          state_q      <= trunc_q ? S_TRUNC : S_DONE;
        end
        S_TRUNC: begin
          trunc_q <= 1'b0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // result output: a new result pushes out the held one, done releases it last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q    <= 1'b0;
      pend_status_q <= ST_MATCH;
      pend_start_q  <= '0;
      pend_end_q    <= '0;
      res_cnt_q     <= '0;
      strobe_q      <= 1'b0;
      status_q      <= ST_MATCH;
      rs_q          <= '0;
      re_q          <= '0;
      lr_q          <= 1'b0;
    end else begin
      if (emit_req && (res_cnt_q < RCW'(MAX_RESULTS))) begin
        strobe_q <= pend_vld_q;
        if (pend_vld_q) begin
          status_q <= pend_status_q;
          rs_q     <= pend_start_q;
          re_q     <= pend_end_q;
          lr_q     <= 1'b0;
        end
        pend_vld_q    <= 1'b1;
        pend_status_q <= emit_status;
        pend_start_q  <= emit_start;
        pend_end_q    <= emit_end;
        res_cnt_q     <= res_cnt_q + RCW'(1);
      end else if (state_q == S_DONE) begin
        strobe_q <= pend_vld_q;
        if (pend_vld_q) begin
          status_q <= pend_status_q;
          rs_q     <= pend_start_q;
          re_q     <= pend_end_q;
          lr_q     <= 1'b1;
        end
        pend_vld_q <= 1'b0;
        res_cnt_q  <= '0;
      end else begin
        strobe_q <= 1'b0;
      end
    end
  end

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign range_start_o  = rs_q;
  assign range_end_o    = re_q;
  assign last_result_o  = lr_q;

endmodule

FILE: src/ngm_checker.sv
// ----------------------------------------------------------------------------
// ngm_checker
// port-level checks of the keyword n-gram matcher
// ----------------------------------------------------------------------------
module ngm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic [1:0]                    status_o,
  input logic [ngm_pkg::OUT_POS_W-1:0] range_start_o,
  input logic [ngm_pkg::OUT_POS_W-1:0] range_end_o,
  input logic                          last_result_o
);

  import ngm_pkg::*;

  // every accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the block busy");

  // status results carry zero positions
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_MATCH) |->
      (range_start_o == '0) && (range_end_o == '0))
    else $error("status result with nonzero positions");

  // more results are due after a non-final one
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy)
    else $error("non-final result while idle");

  // pattern errors are the only result of their transaction
  a_pat_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((status_o == ST_TABLE_FULL) || (status_o == ST_TOO_LONG))
      |-> last_result_o)
    else $error("pattern error not marked as last result");

endmodule

bind token_ngram_keyword_matcher ngm_checker u_ngm_checker (.*);

FILE: verif/tb_token_ngram_keyword_matcher.sv
// ----------------------------------------------------------------------------
// tb_token_ngram_keyword_matcher
// self-checking bench: loads keyword n-grams, streams texts through the block
// in match and join mode, and compares every result strobe with a predictor
// that tracks its own copy of the table, the window and the range state
// ----------------------------------------------------------------------------
module tb_token_ngram_keyword_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import ngm_pkg::*;

  localparam int unsigned SPAN     = DEF_MAX_SPAN;
  localparam int unsigned NPAT     = DEF_NUM_PATTERNS;
  localparam int unsigned TOK_W    = DEF_TOKEN_BITS;
  localparam int unsigned TEXT_LEN = DEF_MAX_TEXT_LEN;
  // command code the block has to ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // settle time after the last result, one full table scan plus margin
  localparam int unsigned DRAIN = NPAT + 64;

  typedef logic [TOK_W-1:0] tok_t;

  typedef struct {
    status_e              status;
    logic [OUT_POS_W-1:0] first;
    logic [OUT_POS_W-1:0] final_pos;
    logic                 tail;
  } hit_t;

  // scoreboard: predicts results of each accepted transaction, checks strobes
  class match_scoreboard;
    tok_t        tbl_tok[NPAT][SPAN];
    int unsigned tbl_len[NPAT];
    int unsigned n_pat;
    int unsigned fill;
    bit          overlong;
    tok_t        stage[SPAN];
    tok_t        win[SPAN];
    int unsigned text_pos;
    bit [7:0]    cov;
    int unsigned open_start;
    bit          range_open;
    bit          join_mode;
    hit_t        pending[$];
    hit_t        step_hits[$];
    int unsigned errors;

    function void clear_text();
      foreach (win[i]) win[i] = '0;
      text_pos   = 0;
      cov        = '0;
      open_start = 0;
      range_open = 0;
    endfunction

    function void clear_stage();
      fill     = 0;
      overlong = 0;
      foreach (stage[i]) stage[i] = '0;
    endfunction

    function void init();
      n_pat     = 0;
      join_mode = 0;
      errors    = 0;
      clear_stage();
      clear_text();
    endfunction

    function bit known(tok_t s[SPAN], int unsigned off, int unsigned len);
      bit same;
      for (int unsigned k = 0; k < n_pat; k++) begin
        if (tbl_len[k] != len) continue;
        same = 1;
        for (int unsigned i = 0; i < len; i++)
          if (tbl_tok[k][i] != s[off+i]) same = 0;
        if (same) return 1;
      end
      return 0;
    endfunction

    function void add_hit(status_e st, int unsigned a, int unsigned b);
      hit_t h;
      if (step_hits.size() >= MAX_RESULTS) return;
      h.status    = st;
      h.first     = a[OUT_POS_W-1:0];
      h.final_pos = b[OUT_POS_W-1:0];
      h.tail      = 0;
      step_hits = {step_hits, h};
    endfunction

    // all n-grams beginning at window slot j, longest first
    function void scan_start(int unsigned j, int unsigned pos);
      for (int len = SPAN - j; len >= 1; len--) begin
        if (known(win, j, len)) begin
          cov |= ((8'd1 << len) - 8'd1) << j;
          if (!join_mode) add_hit(ST_MATCH, pos, pos + len - 1);
        end
      end
    endfunction

    // slot j can gain no more coverage, open or close a range
    function void settle(int unsigned j, int unsigned pos);
      bit hit;
      hit = cov[j];
      if (hit && !range_open) begin
        open_start = pos;
        range_open = 1;
      end else if (!hit && range_open) begin
        if (join_mode) add_hit(ST_MATCH, open_start, pos - 1);
        range_open = 0;
      end
    endfunction

    // end of text: remaining starts, then an open range
    function void flush(int unsigned lp);
      int unsigned valid, j;
      valid = (lp + 1 < SPAN) ? lp + 1 : SPAN;
      j = SPAN - valid;
      if (j == 0) j = 1;
      for (; j < SPAN; j++) begin
        scan_start(j, lp + 1 + j - SPAN);
        settle(j, lp + 1 + j - SPAN);
      end
      if (range_open && join_mode) add_hit(ST_MATCH, open_start, lp);
    endfunction

    function void pattern_tok(tok_t tok, bit last);
      if (fill < SPAN) begin
        stage[fill] = tok;
        fill++;
      end else begin
        overlong = 1;
      end
      if (!last) return;
      if (overlong) begin
        add_hit(ST_TOO_LONG, 0, 0);
      end else if (!known(stage, 0, fill)) begin
        if (n_pat >= NPAT) begin
          add_hit(ST_TABLE_FULL, 0, 0);
        end else begin
          for (int unsigned i = 0; i < SPAN; i++) tbl_tok[n_pat][i] = stage[i];
          tbl_len[n_pat] = fill;
          n_pat++;
        end
      end
      clear_stage();
    endfunction

    function void text_tok(tok_t tok, bit last);
      int unsigned p;
      if (text_pos >= TEXT_LEN) begin
        if (last) begin
          flush(TEXT_LEN - 1);
          add_hit(ST_TRUNCATED, 0, 0);
          clear_text();
        end
        return;
      end
      for (int unsigned i = 0; i + 1 < SPAN; i++) win[i] = win[i+1];
      win[SPAN-1] = tok;
      cov >>= 1;
      p = text_pos;
      text_pos++;
      if (p >= SPAN - 1) begin
        scan_start(0, p + 1 - SPAN);
        settle(0, p + 1 - SPAN);
      end
      if (last) begin
        flush(p);
        clear_text();
      end
    endfunction

    // accepted transaction: queue what it must produce
    function void note_input(logic [1:0] cmd, tok_t tok, logic last);
      step_hits.delete();
      case (cmd)
        CMD_PATTERN: pattern_tok(tok, last);
        CMD_TEXT:    text_tok(tok, last);
        CMD_CLEAR: begin
          n_pat = 0;
          clear_stage();
        end
        default: ;
      endcase
      if (step_hits.size() > 0) step_hits[step_hits.size()-1].tail = 1;
      pending = {pending, step_hits};
    endfunction

    function void check_result(logic [1:0] st, logic [OUT_POS_W-1:0] a,
                               logic [OUT_POS_W-1:0] b, logic tail);
      hit_t h;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d start=%0d end=%0d", st, a, b);
        errors++;
        return;
      end
      h = pending.pop_front();
      if (st !== h.status) begin
        $error("status: expected %0d, got %0d", h.status, st);
        errors++;
      end
      if (a !== h.first) begin
        $error("range_start: expected %0d, got %0d", h.first, a);
        errors++;
      end
      if (b !== h.final_pos) begin
        $error("range_end: expected %0d, got %0d", h.final_pos, b);
        errors++;
      end
      if (tail !== h.tail) begin
        $error("last_result: expected %0d, got %0d", h.tail, tail);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 start = 0;
  logic                 busy;
  logic [1:0]           cmd_i = CMD_PATTERN;
  tok_t                 token_i = '0;
  logic                 last_i = 0;
  logic                 cfg_we_i = 0;
  logic                 cfg_wdata_i = 0;
  logic                 result_valid_o;
  logic [1:0]           status_o;
  logic [OUT_POS_W-1:0] range_start_o;
  logic [OUT_POS_W-1:0] range_end_o;
  logic                 last_result_o;

  match_scoreboard sb = new();

  // sender burst control
  int unsigned burst_left = 0;
  bit          no_gaps    = 0;
  int unsigned n_items    = 0;

  token_ngram_keyword_matcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .token_i       (token_i),
    .last_i        (last_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .range_start_o (range_start_o),
    .range_end_o   (range_end_o),
    .last_result_o (last_result_o)
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // monitor: transactions, register writes and result strobes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_input(cmd_i, token_i, last_i);
      if (cfg_we_i) sb.join_mode = cfg_wdata_i;
      if (result_valid_o)
        sb.check_result(status_o, range_start_o, range_end_o, last_result_o);
    end
  end

  // one transaction; start stays high into the next one inside a burst
  task automatic send(logic [1:0] cmd, tok_t tok, logic last);
    @(negedge clk_i);
    if (!no_gaps && burst_left == 0) begin
      start = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    start   = 1;
    cmd_i   = cmd;
    token_i = tok;
    last_i  = last;
    do @(posedge clk_i); while (busy);
    n_items++;
  endtask

  // drop start and let the block finish all queued work
  task automatic go_idle();
    @(negedge clk_i);
    start = 0;
    burst_left = 0;
    while (sb.pending.size() != 0 || busy) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic set_join(bit m);
    go_idle();
    cfg_wdata_i = m;
    cfg_we_i    = 1;
    @(negedge clk_i);
    cfg_we_i    = 0;
  endtask

  task automatic load_pattern(tok_t p[$]);
    foreach (p[i]) send(CMD_PATTERN, p[i], i == p.size() - 1);
  endtask

  task automatic feed_text(tok_t t[$]);
    foreach (t[i]) send(CMD_TEXT, t[i], i == t.size() - 1);
  endtask

  // mostly a small alphabet so n-grams hit, now and then any token id
  function automatic tok_t pick_tok();
    if ($urandom_range(0, 9) == 0) return tok_t'($urandom);
    return tok_t'($urandom_range(1, 5));
  endfunction

  initial begin
    tok_t seq[$];
    int unsigned len, kind;

    sb.init();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: both modes, extreme token ids, duplicates, unused code
    set_join(0);
    load_pattern('{tok_t'(1)});
    load_pattern('{tok_t'(1), tok_t'(2)});
    load_pattern('{tok_t'(2), tok_t'(3), tok_t'(4)});
    load_pattern('{tok_t'('1), tok_t'(0), tok_t'(1), tok_t'(2)});
    load_pattern('{tok_t'(1), tok_t'(2)});                 // duplicate
    feed_text('{tok_t'(1), tok_t'(2), tok_t'(3), tok_t'(4),
                tok_t'('1), tok_t'(0), tok_t'(1), tok_t'(2)});
    feed_text('{tok_t'(1)});                                // one-token text
    send(CMD_UNUSED, tok_t'('1), 1);
    set_join(1);
    feed_text('{tok_t'(1), tok_t'(2), tok_t'(3), tok_t'(4), tok_t'(9), tok_t'(1)});
    // pattern arriving while a text is open
    send(CMD_TEXT, tok_t'(7), 0);
    load_pattern('{tok_t'(7), tok_t'(8)});
    feed_text('{tok_t'(8), tok_t'(7)});
    // mode switch inside a text
    send(CMD_TEXT, tok_t'(1), 0);
    send(CMD_TEXT, tok_t'(2), 0);
    set_join(0);
    feed_text('{tok_t'(3), tok_t'(4)});
    // overlong pattern, then clear with a half loaded pattern pending
    load_pattern('{tok_t'(1), tok_t'(2), tok_t'(3), tok_t'(4), tok_t'(5)});
    send(CMD_PATTERN, tok_t'(3), 0);
    send(CMD_CLEAR, '0, 0);
    feed_text('{tok_t'(1), tok_t'(2)});

    // full table: distinct single tokens, one more new, one duplicate
    for (int unsigned i = 0; i < NPAT; i++) send(CMD_PATTERN, tok_t'(1000 + i), 1);
    send(CMD_PATTERN, tok_t'(5), 1);
    send(CMD_PATTERN, tok_t'(1000), 1);
    send(CMD_CLEAR, '0, 1);

    // overlong text running past TEXT_LEN tokens, so it is truncated, back to back
    go_idle();
    load_pattern('{tok_t'(2), tok_t'(3)});
    no_gaps = 1;
    for (int unsigned i = 0; i < TEXT_LEN + 2; i++)
      send(CMD_TEXT, tok_t'($urandom_range(1, 3)), i == TEXT_LEN + 1);
    no_gaps = 0;
    send(CMD_CLEAR, '0, 0);

    // random: mostly well formed patterns and texts, some noise
    n_items = 0;
    while (n_items < 230) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        set_join($urandom_range(0, 1));
      end else if (kind == 1) begin
        send(CMD_CLEAR, pick_tok(), $urandom_range(0, 1));
      end else if (kind == 2) begin
        send(CMD_UNUSED, tok_t'($urandom), $urandom_range(0, 1));
      end else if (kind < 9) begin
        seq.delete();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, SPAN);
        repeat (len) seq = {seq, pick_tok()};
        load_pattern(seq);
      end else begin
        seq.delete();
        len = $urandom_range(1, 12);
        repeat (len) seq = {seq, pick_tok()};
        feed_text(seq);
      end
    end

    go_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

endmodule
